[rtl/crc8fr_pkg.sv]
// Shared types, constants and the CRC-8 step function of the framed receiver.
// Used by every module of the block but crc8fr_ram; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package crc8fr_pkg;

  // Largest payload a frame may carry
  localparam int MAX_LEN = 64;
  // Field widths of the result items
  localparam int IDX_W   = 6;
  localparam int LEN_W   = 7;
  // Payload RAM holds two banks of MAX_LEN bytes
  localparam int RAM_DEPTH = 2 * MAX_LEN;
  localparam int RAM_AW    = IDX_W + 1;

  // Input operation codes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_START   = 2'd0;
  localparam logic [1:0] CFG_END     = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT = 2'd2;

  // Reset values of the configuration registers
  localparam logic [7:0]  START_RST   = 8'hAA;
  localparam logic [7:0]  END_RST     = 8'h55;
  localparam logic [15:0] TIMEOUT_RST = 16'd1000;

  // CRC-8 generator polynomial
  localparam logic [7:0] CRC_POLY = 8'h07;

  // Descriptor of a completed frame waiting for playback
  typedef struct packed {
    logic [7:0]       id;
    logic [LEN_W-1:0] len;
    logic             bank;
  } frame_desc_t;

  // One byte through the CRC-8, MSB first
  function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] v;
    v = acc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (v[7]) begin
        v = {v[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

`default_nettype wire

[rtl/crc8fr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
`timescale 1ns / 1ps
`default_nettype none

module crc8fr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/crc8fr_front.sv]
// Front end: frame parser, incremental CRC-8, idle countdown and config registers.
// Writes payload bytes to the RAM and pushes finished frames; uses crc8fr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module crc8fr_front
  import crc8fr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  // input channel
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              op,
  input  wire logic [7:0]        rx_byte,
  // configuration
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [15:0]       cfg_data,
  // both payload banks hold queued or playing frames
  input  wire logic              banks_full,
  // payload RAM write port
  output logic                   ram_we,
  output logic [RAM_AW-1:0]      ram_waddr,
  output logic [7:0]             ram_wdata,
  // completed frame
  output logic                   push,
  output frame_desc_t            push_desc
);

  typedef enum logic [2:0] {
    PH_SOF,
    PH_ID,
    PH_LEN,
    PH_DATA,
    PH_CRC,
    PH_EOF
  } phase_t;

  phase_t           phase;
  logic [7:0]       start_marker;
  logic [7:0]       end_marker;
  logic [15:0]      timeout_ticks;
  logic [7:0]       held_id;
  logic [LEN_W-1:0] expected_length;
  logic [LEN_W-1:0] received_count;
  logic [7:0]       running_crc;
  logic [15:0]      idle_countdown;
  logic             wbank;

  logic             take;
  logic             take_byte;
  logic [LEN_W-1:0] count_inc;
  logic [7:0]       crc_in;
  logic [7:0]       crc_next;

  assign in_ready  = !banks_full;
  assign take      = in_valid && in_ready;
  assign take_byte = take && (op == OP_BYTE);
  assign count_inc = received_count + LEN_W'(1);

  // CRC restarts from zero on the id byte
  assign crc_in   = (phase == PH_ID) ? 8'h00 : running_crc;
  assign crc_next = crc8_step(crc_in, rx_byte);

  // Store payload bytes into the bank being filled
  assign ram_we    = take_byte && (phase == PH_DATA);
  assign ram_waddr = {wbank, received_count[IDX_W-1:0]};
  assign ram_wdata = rx_byte;

  // Hand a frame over once its end marker checks out
  assign push           = take_byte && (phase == PH_EOF) && (rx_byte == end_marker);
  assign push_desc.id   = held_id;
  assign push_desc.len  = expected_length;
  assign push_desc.bank = wbank;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_SOF;
      start_marker    <= START_RST;
      end_marker      <= END_RST;
      timeout_ticks   <= TIMEOUT_RST;
      held_id         <= '0;
      expected_length <= '0;
      received_count  <= '0;
      running_crc     <= '0;
      idle_countdown  <= TIMEOUT_RST;
      wbank           <= 1'b0;
    end else begin
      // configuration writes; out-of-range index is dropped
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_START:   start_marker  <= cfg_data[7:0];
          CFG_END:     end_marker    <= cfg_data[7:0];
          CFG_TIMEOUT: timeout_ticks <= cfg_data;
          default:     ;
        endcase
      end

      if (take && (op == OP_TICK)) begin
        // count down, clear the parser once the countdown is spent
        if (idle_countdown != 16'd0) begin
          idle_countdown <= idle_countdown - 16'd1;
        end else begin
          phase           <= PH_SOF;
          held_id         <= '0;
          expected_length <= '0;
          received_count  <= '0;
          running_crc     <= '0;
        end
      end else if (take_byte) begin
        idle_countdown <= timeout_ticks;
        unique case (phase)
          PH_SOF: begin
            if (rx_byte == start_marker) begin
              received_count <= '0;
              phase          <= PH_ID;
            end
          end
          PH_ID: begin
            held_id     <= rx_byte;
            running_crc <= crc_next;
            phase       <= PH_LEN;
          end
          PH_LEN: begin
            if (rx_byte > 8'(MAX_LEN)) begin
              phase <= PH_SOF;
            end else begin
              expected_length <= rx_byte[LEN_W-1:0];
              received_count  <= '0;
              running_crc     <= crc_next;
              phase           <= (rx_byte == 8'd0) ? PH_CRC : PH_DATA;
            end
          end
          PH_DATA: begin
            running_crc    <= crc_next;
            received_count <= count_inc;
            if (count_inc >= expected_length) begin
              phase <= PH_CRC;
            end
          end
          PH_CRC: begin
            phase <= (rx_byte == running_crc) ? PH_EOF : PH_SOF;
          end
          PH_EOF: begin
            // the next frame fills the other bank
            if (rx_byte == end_marker) begin
              wbank <= !wbank;
            end
            phase <= PH_SOF;
          end
          default: phase <= PH_SOF;
        endcase
      end
    end
  end

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    expected_length <= LEN_W'(MAX_LEN))
    else $error("front: expected length above buffer size");
  a_bank_flip: assert property (@(posedge clk) disable iff (rst)
    push |=> (wbank != $past(wbank)))
    else $error("front: fill bank did not flip after a frame push");
`endif

endmodule

`default_nettype wire

[rtl/crc8fr_queue.sv]
// Two-entry frame descriptor queue between the parser and the playback unit.
// Uses frame_desc_t from crc8fr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module crc8fr_queue
  import crc8fr_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire frame_desc_t  push_desc,
  input  wire logic         pop,
  output frame_desc_t       head,
  output logic              not_empty,
  output logic [1:0]        count
);

  frame_desc_t slots [2];
  logic        wr_ptr;
  logic        rd_ptr;

  assign head      = slots[rd_ptr];
  assign not_empty = (count != 2'd0);

  // Store descriptors in arrival order
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_desc;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count != 2'd2))
    else $error("queue: push into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != 2'd0))
    else $error("queue: pop from an empty queue");
`endif

endmodule

`default_nettype wire

[rtl/crc8fr_back.sv]
// Back end: plays out a completed frame, one result per byte (one if no payload).
// Reads the payload RAM, takes descriptors from crc8fr_queue; uses crc8fr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module crc8fr_back
  import crc8fr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  // descriptor queue
  input  wire logic              q_not_empty,
  input  wire frame_desc_t       q_head,
  output logic                   pop,
  output logic                   playing,
  // payload RAM read port
  output logic                   ram_re,
  output logic [RAM_AW-1:0]      ram_raddr,
  input  wire logic [7:0]        ram_rdata,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [7:0]             frame_id,
  output logic [LEN_W-1:0]       payload_length,
  output logic [IDX_W-1:0]       byte_index,
  output logic [7:0]             data_byte,
  output logic                   has_data,
  output logic                   last
);

  typedef enum logic {
    BK_IDLE,
    BK_SHOW
  } bk_state_t;

  bk_state_t        state;
  frame_desc_t      cur;
  logic [IDX_W-1:0] idx;
  logic [LEN_W-1:0] idx_inc;
  logic             xfer;
  logic             step;

  assign idx_inc = LEN_W'(idx) + LEN_W'(1);

  assign out_valid      = (state == BK_SHOW);
  assign frame_id       = cur.id;
  assign payload_length = cur.len;
  assign byte_index     = idx;
  assign has_data       = (cur.len != '0);
  assign last           = !has_data || (idx_inc == cur.len);
  assign data_byte      = has_data ? ram_rdata : 8'h00;

  assign playing = (state == BK_SHOW);
  assign xfer    = out_valid && out_ready;
  assign pop     = (state == BK_IDLE) && q_not_empty;
  assign step    = xfer && !last;

  // Fetch byte zero on start, the next byte on each transfer but the last
  assign ram_re    = pop || step;
  assign ram_raddr = pop ? {q_head.bank, {IDX_W{1'b0}}}
                         : {cur.bank, idx_inc[IDX_W-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      idx   <= '0;
    end else begin
      unique case (state)
        BK_IDLE: begin
          if (pop) begin
            cur   <= q_head;
            idx   <= '0;
            state <= BK_SHOW;
          end
        end
        BK_SHOW: begin
          if (step) begin
            idx <= idx_inc[IDX_W-1:0];
          end else if (xfer) begin
            state <= BK_IDLE;
          end
        end
        default: state <= BK_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_idx_in_frame: assert property (@(posedge clk) disable iff (rst)
    (out_valid && has_data) |-> (LEN_W'(byte_index) < payload_length))
    else $error("back: byte index beyond payload length");
  a_idx_advance: assert property (@(posedge clk) disable iff (rst)
    step |=> (out_valid && (byte_index == $past(byte_index) + IDX_W'(1))))
    else $error("back: byte index did not advance after a transfer");
`endif

endmodule

`default_nettype wire

[rtl/crc8_frame_receiver_top.sv]
// Top level of the framed CRC-8 packet receiver.
// Instantiates crc8fr_front, crc8fr_queue, crc8fr_back and crc8fr_ram; uses crc8fr_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Receives bytes and timer ticks on one input channel, one item per cycle while
// in_ready is high. A frame (start marker, id, length, payload, CRC-8 over
// id/length/payload, end marker) that checks out is played back as one result
// per payload byte at one result per cycle while out_ready is high, from the
// cycle after the playback unit picks it up from the descriptor queue; an empty
// payload gives one result with has_data low. The payload RAM has two banks of
// 64 bytes, so the parser keeps taking items while one finished frame plays back;
// in_ready drops while two finished frames are waiting or playing and rises after
// the older one's last result is transferred. There is no clearing pass after
// reset. Configuration registers: 0 start marker, 1 end marker, 2 timeout in ticks.
module crc8_frame_receiver_top
  import crc8fr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  // input channel
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              op,
  input  wire logic [7:0]        rx_byte,
  // configuration
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [15:0]       cfg_data,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [7:0]             frame_id,
  output logic [LEN_W-1:0]       payload_length,
  output logic [IDX_W-1:0]       byte_index,
  output logic [7:0]             data_byte,
  output logic                   has_data,
  output logic                   last
);

  logic              ram_we;
  logic [RAM_AW-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic              ram_re;
  logic [RAM_AW-1:0] ram_raddr;
  logic [7:0]        ram_rdata;
  logic              push;
  frame_desc_t       push_desc;
  logic              pop;
  frame_desc_t       q_head;
  logic              q_not_empty;
  logic [1:0]        q_count;
  logic              playing;
  logic              banks_full;

  // Both banks are taken by queued or playing frames
  assign banks_full = ((q_count + 2'(playing)) >= 2'd2);

  crc8fr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .rx_byte    (rx_byte),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .banks_full (banks_full),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .push       (push),
    .push_desc  (push_desc)
  );

  crc8fr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (q_head),
    .not_empty (q_not_empty),
    .count     (q_count)
  );

  crc8fr_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  crc8fr_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_not_empty    (q_not_empty),
    .q_head         (q_head),
    .pop            (pop),
    .playing        (playing),
    .ram_re         (ram_re),
    .ram_raddr      (ram_raddr),
    .ram_rdata      (ram_rdata),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .frame_id       (frame_id),
    .payload_length (payload_length),
    .byte_index     (byte_index),
    .data_byte      (data_byte),
    .has_data       (has_data),
    .last           (last)
  );

`ifndef SYNTHESIS
  a_bank_guard: assert property (@(posedge clk) disable iff (rst)
    (ram_we && playing) |-> (ram_waddr[RAM_AW-1] != ram_raddr[RAM_AW-1]
                             || !ram_re))
    else $error("top: payload write hit the bank being played");
`endif

endmodule

`default_nettype wire

[dv/testbench.sv]
// Self-checking testbench for crc8_frame_receiver_top: framed bytes and ticks in,
// per-byte frame results out, checked against a parser model kept in this file.
// Depends on crc8fr_pkg and the RTL of the receiver only.
`timescale 1ns / 1ps

module testbench;
  import crc8fr_pkg::*;

  // Unused register index; writes to it must be ignored
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  // Idle cycles after the last result before a register write or the end
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_ITEMS = 96;
  // Watchdog limit on the length of the whole run
  localparam int CYCLE_LIMIT = 400000;

  typedef enum logic [2:0] {
    ST_SOF, ST_ID, ST_LEN, ST_DATA, ST_CRC, ST_EOF
  } rx_phase_t;

  typedef enum int {
    FLAW_NONE, FLAW_BAD_CRC, FLAW_BAD_END, FLAW_TOO_LONG, FLAW_CUT
  } frame_flaw_t;

  typedef struct {
    logic [7:0]       id;
    logic [LEN_W-1:0] len;
    logic [IDX_W-1:0] idx;
    logic [7:0]       data;
    logic             has;
    logic             last;
  } frame_result_t;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic              op;
  logic [7:0]        rx_byte;
  logic              cfg_we;
  logic [1:0]        cfg_index;
  logic [15:0]       cfg_data;
  logic              out_valid;
  logic              out_ready;
  logic [7:0]        frame_id;
  logic [LEN_W-1:0]  payload_length;
  logic [IDX_W-1:0]  byte_index;
  logic [7:0]        data_byte;
  logic              has_data;
  logic              last;

  crc8_frame_receiver_top i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .op             (op),
    .rx_byte        (rx_byte),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .frame_id       (frame_id),
    .payload_length (payload_length),
    .byte_index     (byte_index),
    .data_byte      (data_byte),
    .has_data       (has_data),
    .last           (last)
  );

  // Parser model: register copies and parse state
  logic [7:0]       start_mk;
  logic [7:0]       end_mk;
  logic [15:0]      timeout_cfg;
  rx_phase_t        phase;
  logic [7:0]       cur_id;
  logic [LEN_W-1:0] want_len;
  logic [LEN_W-1:0] got_cnt;
  logic [7:0]       crc_acc;
  logic [7:0]       payload_mem [MAX_LEN];
  logic [15:0]      countdown;

  frame_result_t    due_results[$];
  frame_result_t    front_result;
  logic [7:0]       payload_buf[$];

  int unsigned      fail_count;
  int unsigned      items_sent;
  int unsigned      frames_emitted;
  int unsigned      results_checked;
  int unsigned      cfg_writes;
  int unsigned      cycle_count;
  int unsigned      burst_left;
  int unsigned      ready_hold;
  logic             ready_level;

  // CRC-8, polynomial 0x07, one input bit at a time
  function automatic logic [7:0] crc_next(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] r;
    logic       fb;
    r = acc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[7] ^ b[i];
      r  = {r[6:0], 1'b0} ^ (fb ? 8'h07 : 8'h00);
    end
    return r;
  endfunction

  function automatic void clear_parser();
    phase    = ST_SOF;
    cur_id   = '0;
    want_len = '0;
    got_cnt  = '0;
    crc_acc  = '0;
  endfunction

  // Push the results of a frame that closed correctly
  function automatic void queue_frame();
    frame_result_t r;
    r.id  = cur_id;
    r.len = want_len;
    if (want_len == 0) begin
      r.idx  = '0;
      r.data = '0;
      r.has  = 1'b0;
      r.last = 1'b1;
      due_results.push_back(r);
    end else begin
      for (int k = 0; k < want_len; k++) begin
        r.idx  = IDX_W'(k);
        r.data = payload_mem[k];
        r.has  = 1'b1;
        r.last = (k == want_len - 1);
        due_results.push_back(r);
      end
    end
    frames_emitted++;
  endfunction

  // Advance the parser model by one accepted input item
  function automatic void parse_item(input logic op_i, input logic [7:0] b);
    if (op_i == OP_TICK) begin
      if (countdown != 0) begin
        countdown = countdown - 1'b1;
      end else begin
        clear_parser();
      end
    end else begin
      case (phase)
        ST_SOF: begin
          if (b == start_mk) begin
            got_cnt = '0;
            phase   = ST_ID;
          end
        end
        ST_ID: begin
          cur_id  = b;
          crc_acc = crc_next(8'h00, b);
          phase   = ST_LEN;
        end
        ST_LEN: begin
          if (b > MAX_LEN) begin
            phase = ST_SOF;
          end else begin
            want_len = LEN_W'(b);
            got_cnt  = '0;
            crc_acc  = crc_next(crc_acc, b);
            phase    = (b == 0) ? ST_CRC : ST_DATA;
          end
        end
        ST_DATA: begin
          if (got_cnt < MAX_LEN) begin
            payload_mem[got_cnt[IDX_W-1:0]] = b;
          end
          crc_acc = crc_next(crc_acc, b);
          got_cnt = got_cnt + 1'b1;
          if (got_cnt >= want_len) begin
            phase = ST_CRC;
          end
        end
        ST_CRC: begin
          phase = (b == crc_acc) ? ST_EOF : ST_SOF;
        end
        ST_EOF: begin
          if (b == end_mk) begin
            queue_frame();
          end
          phase = ST_SOF;
        end
        default: begin
          phase = ST_SOF;
        end
      endcase
      countdown = timeout_cfg;
    end
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  // Clock and watchdog
  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_count,
               due_results.size());
      $display("FAIL");
      $finish;
    end
  end

  // Receiver stalls: long open stretches, stall runs and fast toggling
  always @(negedge clk) begin
    if (ready_hold == 0) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          ready_level = 1'b1;
          ready_hold  = $urandom_range(30, 150);
        end
        2: begin
          ready_level = 1'b0;
          ready_hold  = $urandom_range(5, 20);
        end
        default: begin
          ready_level = 1'($urandom_range(0, 1));
          ready_hold  = $urandom_range(1, 3);
        end
      endcase
    end
    ready_hold--;
    out_ready <= ready_level;
  end

  // Compare every result transfer with the oldest due result
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        $error("unexpected result: frame_id %0h byte_index %0d", frame_id, byte_index);
        fail_count++;
      end else begin
        front_result = due_results.pop_front();
        check_field("frame_id", front_result.id, frame_id);
        check_field("payload_length", front_result.len, payload_length);
        check_field("byte_index", front_result.idx, byte_index);
        check_field("data_byte", front_result.data, data_byte);
        check_field("has_data", front_result.has, has_data);
        check_field("last", front_result.last, last);
        results_checked++;
      end
    end
  end

  // Sender pacing: bursts of random length, random gaps, some long clean runs
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 15) : $urandom_range(0, 4);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
    end
  endtask

  // Offer one item and hold it until the transfer
  task automatic send_item(input logic op_i, input logic [7:0] b);
    @(negedge clk);
    in_valid <= 1'b1;
    op       <= op_i;
    rx_byte  <= b;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    parse_item(op_i, b);
    items_sent++;
    pace_sender();
  endtask

  // Drop valid and wait until every due result has come out
  task automatic hold_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [15:0] data);
    hold_until_drained();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      CFG_START:   start_mk    = data[7:0];
      CFG_END:     end_mk      = data[7:0];
      CFG_TIMEOUT: timeout_cfg = data;
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Send a frame around payload_buf; id_ticks ticks follow the id byte
  task automatic send_frame(input logic [7:0] id, input frame_flaw_t flaw,
                            input int tick_pct, input int id_ticks);
    logic [7:0] crc;
    logic [7:0] len_byte;
    logic [7:0] stream[$];
    int         cut_at;
    len_byte = 8'(payload_buf.size());
    if (flaw == FLAW_TOO_LONG) len_byte = 8'($urandom_range(MAX_LEN + 1, 255));
    crc = crc_next(crc_next(8'h00, id), len_byte);
    stream.push_back(start_mk);
    stream.push_back(id);
    stream.push_back(len_byte);
    for (int k = 0; k < payload_buf.size(); k++) begin
      stream.push_back(payload_buf[k]);
      crc = crc_next(crc, payload_buf[k]);
    end
    if (flaw == FLAW_BAD_CRC) crc = crc ^ (8'h01 << $urandom_range(0, 7));
    stream.push_back(crc);
    stream.push_back((flaw == FLAW_BAD_END) ? (end_mk ^ 8'($urandom_range(1, 255))) : end_mk);
    cut_at = (flaw == FLAW_CUT) ? $urandom_range(1, stream.size() - 2) : stream.size();
    for (int k = 0; k < cut_at; k++) begin
      if ($urandom_range(0, 99) < tick_pct) send_item(OP_TICK, 8'($urandom));
      send_item(OP_BYTE, stream[k]);
      if (k == 1) begin
        repeat (id_ticks) send_item(OP_TICK, 8'($urandom));
      end
    end
    // Let the countdown expire on a truncated frame
    if (flaw == FLAW_CUT) begin
      repeat (timeout_cfg + 2) send_item(OP_TICK, 8'($urandom));
    end
  endtask

  task automatic send_random_frame(input int tick_pct);
    int          len;
    int          pick;
    frame_flaw_t flaw;
    pick = $urandom_range(0, 99);
    if (pick < 78) len = $urandom_range(0, 6);
    else if (pick < 95) len = $urandom_range(7, 24);
    else len = $urandom_range(48, MAX_LEN);
    payload_buf.delete();
    for (int k = 0; k < len; k++) payload_buf.push_back(8'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 70) flaw = FLAW_NONE;
    else if (pick < 78) flaw = FLAW_BAD_CRC;
    else if (pick < 86) flaw = FLAW_BAD_END;
    else if (pick < 93) flaw = FLAW_TOO_LONG;
    else flaw = (timeout_cfg <= 40) ? FLAW_CUT : FLAW_BAD_CRC;
    // Line noise ahead of the frame
    if ($urandom_range(0, 9) == 0) send_item(1'($urandom_range(0, 1)), 8'($urandom));
    send_frame(8'($urandom), flaw, tick_pct, 0);
  endtask

  // Field extremes and the too-long, bad-CRC and bad-end drops, default markers
  task automatic test_directed();
    payload_buf.delete();
    send_frame(8'h00, FLAW_NONE, 0, 0);
    payload_buf.push_back(8'hFF);
    send_frame(8'hFF, FLAW_NONE, 0, 0);
    // Length one above the buffer size
    send_item(OP_BYTE, start_mk);
    send_item(OP_BYTE, 8'h01);
    send_item(OP_BYTE, 8'(MAX_LEN + 1));
    payload_buf.delete();
    send_frame(8'h5A, FLAW_BAD_CRC, 0, 0);
    payload_buf.push_back(8'h00);
    send_frame(8'hA5, FLAW_BAD_END, 0, 0);
    // Stray byte and a tick while waiting for a start marker
    send_item(OP_BYTE, 8'h00);
    send_item(OP_TICK, 8'hFF);
  endtask

  // Full-size frames back to back so both payload banks fill up
  task automatic test_max_length();
    payload_buf.delete();
    repeat (MAX_LEN) payload_buf.push_back(8'hFF);
    send_frame(8'h80, FLAW_NONE, 0, 0);
    repeat (2) begin
      payload_buf.delete();
      repeat (MAX_LEN) payload_buf.push_back(8'($urandom));
      send_frame(8'($urandom), FLAW_NONE, 0, 0);
    end
    payload_buf.delete();
    payload_buf.push_back(8'h00);
    send_frame(8'h7F, FLAW_NONE, 0, 0);
  endtask

  // Idle countdown: zero timeout, the exact expiry point, late register change
  task automatic test_timeout();
    logic [7:0] crc;
    cfg_write(CFG_TIMEOUT, 16'd0);
    send_item(OP_BYTE, start_mk);
    send_item(OP_BYTE, 8'h11);
    send_item(OP_TICK, 8'h00);
    payload_buf.delete();
    send_frame(8'h22, FLAW_NONE, 0, 0);
    cfg_write(CFG_TIMEOUT, 16'd3);
    payload_buf.push_back(8'h01);
    payload_buf.push_back(8'h02);
    send_frame(8'h44, FLAW_NONE, 0, 3);
    send_frame(8'h45, FLAW_NONE, 0, 4);
    // A new timeout applies only from the next byte on
    send_item(OP_BYTE, start_mk);
    send_item(OP_BYTE, 8'h33);
    cfg_write(CFG_TIMEOUT, 16'd1);
    repeat (3) send_item(OP_TICK, 8'h00);
    crc = crc_next(crc_next(8'h00, 8'h33), 8'h00);
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, crc);
    send_item(OP_BYTE, end_mk);
    cfg_write(CFG_UNUSED, 16'($urandom));
  endtask

  // Random frames under several register settings, extremes included
  task automatic test_random();
    int         tick_pct;
    int         stop_at;
    logic [7:0] mark;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          cfg_write(CFG_START, 16'($urandom));
          cfg_write(CFG_END, 16'($urandom));
          cfg_write(CFG_TIMEOUT, 16'hFFFF);
          tick_pct = 10;
        end
        1: begin
          cfg_write(CFG_START, 16'h0000);
          cfg_write(CFG_END, 16'h00FF);
          cfg_write(CFG_TIMEOUT, 16'd4);
          tick_pct = 20;
        end
        2: begin
          cfg_write(CFG_START, 16'hFFFF);
          cfg_write(CFG_END, 16'hFF00);
          cfg_write(CFG_TIMEOUT, 16'd0);
          tick_pct = 3;
        end
        default: begin
          mark = 8'($urandom);
          cfg_write(CFG_START, {8'($urandom), mark});
          cfg_write(CFG_END, {8'($urandom), mark});
          cfg_write(CFG_TIMEOUT, 16'd12);
          tick_pct = 15;
        end
      endcase
      stop_at = items_sent + RANDOM_ITEMS / 4;
      while (items_sent < stop_at) begin
        send_random_frame(tick_pct);
        if ($urandom_range(0, 29) == 0) hold_until_drained();
      end
    end
  endtask

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    op          = OP_BYTE;
    rx_byte     = '0;
    cfg_we      = 1'b0;
    cfg_index   = CFG_START;
    cfg_data    = '0;
    out_ready   = 1'b0;
    ready_hold  = 0;
    ready_level = 1'b0;
    burst_left  = 0;
    fail_count      = 0;
    items_sent      = 0;
    frames_emitted  = 0;
    results_checked = 0;
    cfg_writes      = 0;
    cycle_count     = 0;
    start_mk    = START_RST;
    end_mk      = END_RST;
    timeout_cfg = TIMEOUT_RST;
    countdown   = TIMEOUT_RST;
    clear_parser();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_max_length();
    test_timeout();
    test_random();

    hold_until_drained();
    $display("Sent %0d input transfers with %0d register writes across marker and timeout",
             items_sent, cfg_writes);
    $display("extremes; %0d frames accepted, %0d results checked", frames_emitted,
             results_checked);
    if (fail_count == 0 && due_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
